[hdl/tcpq_pkg.sv]
package tcpq_pkg;

  localparam int unsigned KEY_W = 30;
  localparam int unsigned TAG_W = 16;
  localparam int unsigned CAP_W = 5;
  localparam int unsigned OCC_W = 5;
  localparam int unsigned ACT_W = 2;
  localparam int unsigned ST_W  = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

  localparam logic [ACT_W-1:0] ACT_INSERT   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_POP_HEAD = 2'd2;
  localparam logic [ACT_W-1:0] ACT_POP_TAIL = 2'd3;

  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [KEY_W-1:0] key;
    logic             urgent;
    logic [TAG_W-1:0] tag;
  } cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [KEY_W-1:0] removed_key;
    logic [TAG_W-1:0] removed_tag;
    logic [OCC_W-1:0] occupancy;
    logic             head_valid;
    logic [KEY_W-1:0] head_key;
    logic             head_urgent;
  } res_t;

endpackage

[hdl/tcpq_slot_ram.sv]
module tcpq_slot_ram #(
  parameter int unsigned DEPTH_N = 16,
  parameter int unsigned WIDTH   = 47,
  localparam int unsigned AW     = $clog2(DEPTH_N)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH_N];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hdl/tcpq_seq.sv]
module tcpq_seq #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned TAG_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  output logic                       cmd_ready_o,
  input  tcpq_pkg::cmd_t             cmd_i,
  input  logic [tcpq_pkg::CAP_W-1:0] cap_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output tcpq_pkg::res_t             res_o
);

  // count can never pass the 5-bit limit register
  localparam int unsigned MAXN = (DEPTH < 31) ? DEPTH : 31;
  localparam int unsigned CW   = $clog2(MAXN + 1);
  localparam int unsigned AW   = $clog2(MAXN);
  localparam int unsigned TW   = (TAG_BITS < tcpq_pkg::TAG_W) ? TAG_BITS : tcpq_pkg::TAG_W;
  localparam int unsigned KW   = tcpq_pkg::KEY_W;
  localparam int unsigned EW   = 1 + KW + TW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SHR   = 4'd1;
  localparam logic [3:0] S_INS   = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_POP   = 4'd4;
  localparam logic [3:0] S_POPW  = 4'd5;
  localparam logic [3:0] S_SHL   = 4'd6;
  localparam logic [3:0] S_SHLW  = 4'd7;
  localparam logic [3:0] S_HEAD  = 4'd8;
  localparam logic [3:0] S_HEADW = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, ucnt_q, ucnt_d;
  logic mv_q, mv_d, chk_q, chk_d, tailchk_q, tailchk_d;
  logic first_q, first_d, issue_q, issue_d;

  logic [KW-1:0] key_q, key_d;
  logic urg_q, urg_d;
  logic [TW-1:0] tag_q, tag_d;
  logic [tcpq_pkg::ST_W-1:0] status_q, status_d;
  logic [KW-1:0] rk_q, rk_d;
  logic [TW-1:0] rt_q, rt_d;
  logic rurg_q, rurg_d, thit_q, thit_d;
  logic [AW-1:0] ptr_q, ptr_d, pos_q, pos_d, mvdst_q, mvdst_d, chkidx_q, chkidx_d;
  logic [KW-1:0] hk_q, hk_d;
  logic hu_q, hu_d;

  logic rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] rd_data, wr_data;
  logic [KW-1:0] rd_key;
  logic [TW-1:0] rd_tag;
  logic rd_urg, key_hit;

  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] tail_idx, ins_pos;
  logic [tcpq_pkg::CAP_W-1:0] limit;
  logic full;

  logic take_en, take_urg;
  logic [AW-1:0] take_pos;
  logic [KW-1:0] take_key;
  logic [TW-1:0] take_tag;

  tcpq_slot_ram #(
    .DEPTH_N (MAXN),
    .WIDTH   (EW)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // entry layout: {urgent, key, tag}
  assign rd_tag  = rd_data[TW-1:0];
  assign rd_key  = rd_data[TW +: KW];
  assign rd_urg  = rd_data[EW-1];
  assign key_hit = (rd_key == key_q);

  assign cnt_m1   = cnt_q - CW'(1);
  assign tail_idx = cnt_m1[AW-1:0];
  assign ins_pos  = cmd_i.urgent ? ucnt_q[AW-1:0] : cnt_q[AW-1:0];
  assign limit    = (cap_i > tcpq_pkg::CAP_W'(MAXN)) ? tcpq_pkg::CAP_W'(MAXN) : cap_i;
  assign full     = (tcpq_pkg::CAP_W'(cnt_q) >= limit);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ucnt_d    = ucnt_q;
    mv_d      = 1'b0;
    chk_d     = 1'b0;
    tailchk_d = 1'b0;
    first_d   = first_q;
    issue_d   = issue_q;
    key_d     = key_q;
    urg_d     = urg_q;
    tag_d     = tag_q;
    status_d  = status_q;
    rk_d      = rk_q;
    rt_d      = rt_q;
    rurg_d    = rurg_q;
    thit_d    = thit_q;
    ptr_d     = ptr_q;
    pos_d     = pos_q;
    mvdst_d   = mvdst_q;
    chkidx_d  = chkidx_q;
    hk_d      = hk_q;
    hu_d      = hu_q;
    rd_en     = 1'b0;
    rd_addr   = ptr_q;
    wr_en     = mv_q;
    wr_addr   = mvdst_q;
    wr_data   = rd_data;
    take_en   = 1'b0;
    take_pos  = pos_q;
    take_key  = rd_key;
    take_tag  = rd_tag;
    take_urg  = rd_urg;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          key_d    = cmd_i.key;
          urg_d    = cmd_i.urgent;
          tag_d    = cmd_i.tag[TW-1:0];
          status_d = tcpq_pkg::ST_DONE;
          rk_d     = '0;
          rt_d     = '0;
          case (cmd_i.action)
            tcpq_pkg::ACT_INSERT: begin
              if (full) begin
                status_d = tcpq_pkg::ST_FULL;
                state_d  = S_HEAD;
              end else begin
                pos_d = ins_pos;
                if (cmd_i.urgent && (ucnt_q != cnt_q)) begin
                  ptr_d   = tail_idx;
                  state_d = S_SHR;
                end else begin
                  state_d = S_INS;
                end
              end
            end
            tcpq_pkg::ACT_REMOVE: begin
              if (cnt_q == '0) begin
                status_d = tcpq_pkg::ST_MISSING;
                state_d  = S_HEAD;
              end else begin
                // tail is read first, then the scan runs from the head
                ptr_d   = tail_idx;
                first_d = 1'b1;
                issue_d = 1'b1;
                thit_d  = 1'b0;
                state_d = S_SCAN;
              end
            end
            default: begin
              if (cnt_q == '0) begin
                status_d = tcpq_pkg::ST_EMPTY;
                state_d  = S_HEAD;
              end else begin
                pos_d   = (cmd_i.action == tcpq_pkg::ACT_POP_HEAD) ? '0 : tail_idx;
                state_d = S_POP;
              end
            end
          endcase
        end
      end
      S_SHR: begin
        rd_en   = 1'b1;
        mv_d    = 1'b1;
        mvdst_d = ptr_q + AW'(1);
        if (ptr_q == pos_q) begin
          state_d = S_INS;
        end else begin
          ptr_d = ptr_q - AW'(1);
        end
      end
      S_INS: begin
        // wait while the last move is still writing
        if (!mv_q) begin
          wr_en   = 1'b1;
          wr_addr = pos_q;
          wr_data = {urg_q, key_q, tag_q};
          cnt_d   = cnt_q + CW'(1);
          if (urg_q) begin
            ucnt_d = ucnt_q + CW'(1);
          end
          state_d = S_HEAD;
        end
      end
      S_SCAN: begin
        if (issue_q) begin
          rd_en     = 1'b1;
          chk_d     = 1'b1;
          chkidx_d  = ptr_q;
          tailchk_d = first_q;
          if (first_q) begin
            first_d = 1'b0;
            ptr_d   = '0;
          end else if (ptr_q == tail_idx) begin
            issue_d = 1'b0;
          end else begin
            ptr_d = ptr_q + AW'(1);
          end
        end
        if (chk_q) begin
          if (tailchk_q) begin
            thit_d = key_hit;
            rk_d   = rd_key;
            rt_d   = rd_tag;
            rurg_d = rd_urg;
          end else if (key_hit) begin
            take_en  = 1'b1;
            take_pos = chkidx_q;
          end else if (thit_q) begin
            // head missed, tail matched
            take_en  = 1'b1;
            take_pos = tail_idx;
            take_key = rk_q;
            take_tag = rt_q;
            take_urg = rurg_q;
          end else if (chkidx_q == tail_idx) begin
            status_d = tcpq_pkg::ST_MISSING;
            rk_d     = '0;
            rt_d     = '0;
            state_d  = S_HEAD;
          end
        end
      end
      S_POP: begin
        rd_en   = 1'b1;
        rd_addr = pos_q;
        state_d = S_POPW;
      end
      S_POPW: begin
        take_en = 1'b1;
      end
      S_SHL: begin
        rd_en   = 1'b1;
        mv_d    = 1'b1;
        mvdst_d = ptr_q - AW'(1);
        if (ptr_q == tail_idx) begin
          state_d = S_SHLW;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      S_SHLW: begin
        cnt_d   = cnt_m1;
        state_d = S_HEAD;
      end
      S_HEAD: begin
        if (cnt_q == '0) begin
          hk_d    = '0;
          hu_d    = 1'b0;
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = '0;
          state_d = S_HEADW;
        end
      end
      S_HEADW: begin
        hk_d    = rd_key;
        hu_d    = rd_urg;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (take_en) begin
      rk_d  = take_key;
      rt_d  = take_tag;
      pos_d = take_pos;
      if (take_urg && (ucnt_q != '0)) begin
        ucnt_d = ucnt_q - CW'(1);
      end
      if (take_pos == tail_idx) begin
        cnt_d   = cnt_m1;
        state_d = S_HEAD;
      end else begin
        ptr_d   = take_pos + AW'(1);
        state_d = S_SHL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      ucnt_q    <= '0;
      mv_q      <= 1'b0;
      chk_q     <= 1'b0;
      tailchk_q <= 1'b0;
      first_q   <= 1'b0;
      issue_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ucnt_q    <= ucnt_d;
      mv_q      <= mv_d;
      chk_q     <= chk_d;
      tailchk_q <= tailchk_d;
      first_q   <= first_d;
      issue_q   <= issue_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    urg_q    <= urg_d;
    tag_q    <= tag_d;
    status_q <= status_d;
    rk_q     <= rk_d;
    rt_q     <= rt_d;
    rurg_q   <= rurg_d;
    thit_q   <= thit_d;
    ptr_q    <= ptr_d;
    pos_q    <= pos_d;
    mvdst_q  <= mvdst_d;
    chkidx_q <= chkidx_d;
    hk_q     <= hk_d;
    hu_q     <= hu_d;
  end

  assign cmd_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  assign res_o.status      = status_q;
  assign res_o.removed_key = rk_q;
  assign res_o.removed_tag = tcpq_pkg::TAG_W'(rt_q);
  assign res_o.occupancy   = tcpq_pkg::OCC_W'(cnt_q);
  assign res_o.head_valid  = (cnt_q != '0);
  assign res_o.head_key    = hk_q;
  assign res_o.head_urgent = hu_q;

  a_urgent_run_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ucnt_q <= cnt_q)
    else $error("urgent run longer than queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAXN))
    else $error("entry count beyond storage");

  a_move_in_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv_q |-> (state_q == S_SHR || state_q == S_INS || state_q == S_SHL ||
              state_q == S_SHLW))
    else $error("slot move pending outside a shift");

  a_empty_head_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && cnt_q == '0) |-> (hk_q == '0 && !hu_q))
    else $error("empty queue reports a head entry");

endmodule

[hdl/two_class_priority_queue_unit.sv]
// Bounded two-class queue: urgent entries form a run at the front, a new
// urgent entry joins the end of that run and a normal one goes to the back.
// Each request on the slave stream gives exactly one response on the master
// stream with status, removed entry, occupancy and the head entry. Slots sit
// in a single-port-read, single-port-write RAM walked by one sequencer with
// one key comparator, so the RAM read port sets the rate. An insert first
// shifts the entries behind its slot up, then writes the new entry; a pop
// reads the entry and shifts the entries behind it down; remove-by-key
// does a tail probe, a scan to the match, then the shift-down of the entries
// behind it. Every response then passes through an output register. No new
// request is taken while one is in work; a finished response waits in the
// output register. capacity_limit resets to 10 and is clamped to the slot
// count.
module two_class_priority_queue_unit #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned TAG_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // action[1:0], key[31:2], tag[47:32]
  input  logic        s_axis_tuser,  // urgent
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], removed_key[31:2], removed_tag[47:32], occupancy[52:48],
  // head_valid[53], head_key[83:54], head_urgent[84], zero pad[87:85]
  output logic [87:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);

  logic [tcpq_pkg::CAP_W-1:0] cap_q;
  tcpq_pkg::cmd_t cmd;
  tcpq_pkg::res_t res, out_q;
  logic res_valid, res_ready, out_valid_q, out_valid_d;

  assign cmd.action = s_axis_tdata[1:0];
  assign cmd.key    = s_axis_tdata[31:2];
  assign cmd.tag    = s_axis_tdata[47:32];
  assign cmd.urgent = s_axis_tuser;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= tcpq_pkg::CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  tcpq_seq #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .cmd_i       (cmd),
    .cap_i       (cap_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.head_urgent, out_q.head_key, out_q.head_valid,
                          out_q.occupancy, out_q.removed_tag, out_q.removed_key,
                          out_q.status};

endmodule
